FILE: sv/ucel_pkg.sv
`timescale 1ns / 1ps

package ucel_pkg;

  localparam int RX_DEPTH = 128;
  localparam int TX_DEPTH = 128;

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int TX_CW = $clog2(TX_DEPTH + 1);

  typedef logic [RX_AW-1:0] rx_addr_t;
  typedef logic [TX_AW-1:0] tx_addr_t;
  typedef logic [RX_CW-1:0] rx_cnt_t;
  typedef logic [TX_CW-1:0] tx_cnt_t;
  typedef logic [RX_CW:0]   rx_sum_t;
  typedef logic [TX_CW:0]   tx_sum_t;

  // Event kinds on the request channel.
  localparam logic [1:0] REQ_LINE  = 2'd0;
  localparam logic [1:0] REQ_TXRDY = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_WRITE = 2'd3;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;

  localparam logic [7:0] ERASE_SEQ [7] = '{8'h1B, 8'h5B, 8'h31, 8'h44, 8'h1B, 8'h5B, 8'h4B};

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RX_PUSH,
    OP_RX_ERASE,
    OP_TX_PUT,
    OP_TX_POP,
    OP_RX_POP
  } op_e;

  typedef enum logic [1:0] {
    SEQ_NONE,
    SEQ_BYTE,
    SEQ_LF_CR,
    SEQ_ERASE
  } seq_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_e        op;
    seq_e       seq;
    logic [7:0] data;
  } cmd_t;

  // Byte k of a transmit sequence.
  function automatic logic [7:0] seq_byte(seq_e s, logic [2:0] k, logic [7:0] d);
    logic [7:0] b;
    b = d;
    case (s)
      SEQ_LF_CR: b = (k == 3'd0) ? CHAR_LF : CHAR_CR;
      SEQ_ERASE: b = (k == 3'd7) ? d : ERASE_SEQ[k];
      default:   b = d;
    endcase
    return b;
  endfunction

  // Index of the last byte of a transmit sequence.
  function automatic logic [2:0] seq_last(seq_e s);
    logic [2:0] n;
    n = 3'd0;
    case (s)
      SEQ_LF_CR: n = 3'd1;
      SEQ_ERASE: n = 3'd6;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: sv/ucel_req_if.sv
`timescale 1ns / 1ps

interface ucel_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;

  modport source (output valid, req_type, data_byte, input ready);
  modport sink   (input valid, req_type, data_byte, output ready);
endinterface

FILE: sv/ucel_rsp_if.sv
`timescale 1ns / 1ps

interface ucel_rsp_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       read_valid;
  logic [7:0] read_byte;
  logic       dropped;
  logic [7:0] rx_level;
  logic [7:0] tx_level;

  modport source (output valid, tx_valid, tx_byte, read_valid, read_byte, dropped,
                  rx_level, tx_level, input ready);
  modport sink   (input valid, tx_valid, tx_byte, read_valid, read_byte, dropped,
                  rx_level, tx_level, output ready);
endinterface

FILE: sv/ucel_front.sv
`timescale 1ns / 1ps

module ucel_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  ucel_req_if.sink        req_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output ucel_pkg::cmd_t  cmd_o
);

  logic echo_q, echo_d;

  always_comb begin
    echo_d = cfg_we_i ? cfg_wdata_i : echo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_q <= 1'b0;
    end else begin
      echo_q <= echo_d;
    end
  end

  assign cmd_valid_o = req_i.valid;
  assign req_i.ready = cmd_ready_i;

  // Classification depends only on the event and the echo mode; FIFO state is
  // resolved in the back end.
  always_comb begin
    logic [7:0] b;
    b = req_i.data_byte;
    cmd_o.op   = ucel_pkg::OP_NONE;
    cmd_o.seq  = ucel_pkg::SEQ_NONE;
    cmd_o.data = b;
    unique case (req_i.req_type)
      ucel_pkg::REQ_LINE: begin
        if (!echo_q) begin
          cmd_o.op = ucel_pkg::OP_RX_PUSH;
        end else if (b == ucel_pkg::CHAR_CR) begin
          cmd_o.op  = ucel_pkg::OP_RX_PUSH;
          cmd_o.seq = ucel_pkg::SEQ_LF_CR;
        end else if (b >= ucel_pkg::CHAR_SPACE && b < ucel_pkg::CHAR_DEL) begin
          cmd_o.op  = ucel_pkg::OP_RX_PUSH;
          cmd_o.seq = ucel_pkg::SEQ_BYTE;
        end else if (b > ucel_pkg::CHAR_DEL) begin
          cmd_o.op = ucel_pkg::OP_RX_PUSH;
        end else if (b == ucel_pkg::CHAR_DEL) begin
          cmd_o.op  = ucel_pkg::OP_RX_ERASE;
          cmd_o.seq = ucel_pkg::SEQ_ERASE;
        end
      end
      ucel_pkg::REQ_TXRDY: cmd_o.op = ucel_pkg::OP_TX_POP;
      ucel_pkg::REQ_READ:  cmd_o.op = ucel_pkg::OP_RX_POP;
      ucel_pkg::REQ_WRITE: begin
        cmd_o.op  = ucel_pkg::OP_TX_PUT;
        cmd_o.seq = (echo_q && b == ucel_pkg::CHAR_LF) ? ucel_pkg::SEQ_LF_CR
                                                       : ucel_pkg::SEQ_BYTE;
      end
      default: cmd_o.op = ucel_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: sv/ucel_cmd_fifo.sv
`timescale 1ns / 1ps

module ucel_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  ucel_pkg::cmd_t  push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output ucel_pkg::cmd_t  pop_cmd_o
);

  ucel_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

FILE: sv/ucel_back.sv
`timescale 1ns / 1ps

module ucel_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  ucel_pkg::cmd_t  cmd_i,
  ucel_rsp_if.source      rsp_o
);

  ucel_pkg::state_e state_q, state_d;

  ucel_pkg::seq_e     seq_q, seq_d;
  logic [2:0]         idx_q, idx_d;
  logic [7:0]         data_q, data_d;
  logic               drop_q, drop_d;
  logic               txv_q, txv_d;
  logic               rdv_q, rdv_d;

  ucel_pkg::rx_addr_t rx_head_q, rx_head_d;
  ucel_pkg::rx_cnt_t  rx_cnt_q, rx_cnt_d;
  ucel_pkg::tx_addr_t tx_head_q, tx_head_d;
  ucel_pkg::tx_cnt_t  tx_cnt_q, tx_cnt_d;

  logic [7:0] rx_mem [ucel_pkg::RX_DEPTH];
  logic [7:0] tx_mem [ucel_pkg::TX_DEPTH];
  logic [7:0] rx_rdata_q, tx_rdata_q;

  logic               rx_we, tx_we, rx_re, tx_re;
  logic [7:0]         rx_wdata, tx_wdata;
  ucel_pkg::rx_addr_t rx_tail;
  ucel_pkg::tx_addr_t tx_tail;
  ucel_pkg::rx_sum_t  rx_sum;
  ucel_pkg::tx_sum_t  tx_sum;
  logic               rx_full, tx_full;
  ucel_pkg::rx_addr_t rx_head_inc;
  ucel_pkg::tx_addr_t tx_head_inc;

  logic       out_valid_q, out_valid_d;
  logic       out_load;
  logic       out_txv_q, out_rdv_q, out_drop_q;
  logic [7:0] out_txb_q, out_rdb_q, out_rxl_q, out_txl_q;
  logic [31:0] rx_cnt_w, tx_cnt_w;

  logic slot_free, start, need_push;

  assign slot_free   = !out_valid_q || rsp_o.ready;
  assign cmd_ready_o = (state_q == ucel_pkg::ST_IDLE) && slot_free;
  assign start       = cmd_ready_o && cmd_valid_i;

  assign rx_full = (rx_cnt_q == ucel_pkg::rx_cnt_t'(ucel_pkg::RX_DEPTH));
  assign tx_full = (tx_cnt_q == ucel_pkg::tx_cnt_t'(ucel_pkg::TX_DEPTH));

  // Write position is head plus count, wrapped once.
  always_comb begin
    rx_sum = ucel_pkg::rx_sum_t'(rx_head_q) + ucel_pkg::rx_sum_t'(rx_cnt_q);
    if (rx_sum >= ucel_pkg::rx_sum_t'(ucel_pkg::RX_DEPTH)) begin
      rx_sum = rx_sum - ucel_pkg::rx_sum_t'(ucel_pkg::RX_DEPTH);
    end
    rx_tail = rx_sum[ucel_pkg::RX_AW-1:0];
    tx_sum = ucel_pkg::tx_sum_t'(tx_head_q) + ucel_pkg::tx_sum_t'(tx_cnt_q);
    if (tx_sum >= ucel_pkg::tx_sum_t'(ucel_pkg::TX_DEPTH)) begin
      tx_sum = tx_sum - ucel_pkg::tx_sum_t'(ucel_pkg::TX_DEPTH);
    end
    tx_tail = tx_sum[ucel_pkg::TX_AW-1:0];
    rx_head_inc = (rx_head_q == ucel_pkg::rx_addr_t'(ucel_pkg::RX_DEPTH - 1))
                  ? '0 : rx_head_q + ucel_pkg::rx_addr_t'(1);
    tx_head_inc = (tx_head_q == ucel_pkg::tx_addr_t'(ucel_pkg::TX_DEPTH - 1))
                  ? '0 : tx_head_q + ucel_pkg::tx_addr_t'(1);
  end

  assign need_push = (cmd_i.op == ucel_pkg::OP_RX_PUSH && !rx_full &&
                      cmd_i.seq != ucel_pkg::SEQ_NONE) ||
                     (cmd_i.op == ucel_pkg::OP_RX_ERASE && rx_cnt_q != '0) ||
                     (cmd_i.op == ucel_pkg::OP_TX_PUT);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ucel_pkg::ST_IDLE: begin
        if (start) begin
          state_d = need_push ? ucel_pkg::ST_PUSH : ucel_pkg::ST_FIN;
        end
      end
      ucel_pkg::ST_PUSH: begin
        if (tx_full || idx_q == ucel_pkg::seq_last(seq_q)) begin
          state_d = ucel_pkg::ST_FIN;
        end
      end
      ucel_pkg::ST_FIN: state_d = ucel_pkg::ST_IDLE;
      default:          state_d = ucel_pkg::ST_IDLE;
    endcase
  end

  // Datapath and FIFO bookkeeping.
  always_comb begin
    seq_d     = seq_q;
    idx_d     = idx_q;
    data_d    = data_q;
    drop_d    = drop_q;
    txv_d     = txv_q;
    rdv_d     = rdv_q;
    rx_head_d = rx_head_q;
    rx_cnt_d  = rx_cnt_q;
    tx_head_d = tx_head_q;
    tx_cnt_d  = tx_cnt_q;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_re     = 1'b0;
    rx_wdata  = cmd_i.data;
    tx_wdata  = ucel_pkg::seq_byte(seq_q, idx_q, data_q);
    out_load  = 1'b0;
    unique case (state_q)
      ucel_pkg::ST_IDLE: begin
        if (start) begin
          seq_d  = cmd_i.seq;
          idx_d  = 3'd0;
          data_d = cmd_i.data;
          drop_d = 1'b0;
          txv_d  = 1'b0;
          rdv_d  = 1'b0;
          case (cmd_i.op)
            ucel_pkg::OP_RX_PUSH: begin
              if (rx_full) begin
                drop_d = 1'b1;
              end else begin
                rx_we    = 1'b1;
                rx_cnt_d = rx_cnt_q + ucel_pkg::rx_cnt_t'(1);
              end
            end
            ucel_pkg::OP_RX_ERASE: begin
              if (rx_cnt_q != '0) begin
                rx_cnt_d = rx_cnt_q - ucel_pkg::rx_cnt_t'(1);
              end
            end
            ucel_pkg::OP_TX_POP: begin
              if (tx_cnt_q != '0) begin
                txv_d     = 1'b1;
                tx_re     = 1'b1;
                tx_head_d = tx_head_inc;
                tx_cnt_d  = tx_cnt_q - ucel_pkg::tx_cnt_t'(1);
              end
            end
            ucel_pkg::OP_RX_POP: begin
              if (rx_cnt_q != '0) begin
                rdv_d     = 1'b1;
                rx_re     = 1'b1;
                rx_head_d = rx_head_inc;
                rx_cnt_d  = rx_cnt_q - ucel_pkg::rx_cnt_t'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ucel_pkg::ST_PUSH: begin
        // A full transmit FIFO ends the sequence; bytes already queued stay.
        if (tx_full) begin
          drop_d = 1'b1;
        end else begin
          tx_we    = 1'b1;
          tx_cnt_d = tx_cnt_q + ucel_pkg::tx_cnt_t'(1);
          idx_d    = idx_q + 3'd1;
        end
      end
      ucel_pkg::ST_FIN: out_load = 1'b1;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ucel_pkg::ST_IDLE;
      rx_head_q   <= '0;
      rx_cnt_q    <= '0;
      tx_head_q   <= '0;
      tx_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rx_head_q   <= rx_head_d;
      rx_cnt_q    <= rx_cnt_d;
      tx_head_q   <= tx_head_d;
      tx_cnt_q    <= tx_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    idx_q  <= idx_d;
    data_q <= data_d;
    drop_q <= drop_d;
    txv_q  <= txv_d;
    rdv_q  <= rdv_d;
  end

  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_tail] <= rx_wdata;
    end
    if (rx_re) begin
      rx_rdata_q <= rx_mem[rx_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_tail] <= tx_wdata;
    end
    if (tx_re) begin
      tx_rdata_q <= tx_mem[tx_head_q];
    end
  end

  assign rx_cnt_w = 32'(rx_cnt_q);
  assign tx_cnt_w = 32'(tx_cnt_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_txv_q  <= txv_q;
      out_txb_q  <= txv_q ? tx_rdata_q : 8'h00;
      out_rdv_q  <= rdv_q;
      out_rdb_q  <= rdv_q ? rx_rdata_q : 8'h00;
      out_drop_q <= drop_q;
      out_rxl_q  <= rx_cnt_w[7:0];
      out_txl_q  <= tx_cnt_w[7:0];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.tx_valid   = out_txv_q;
  assign rsp_o.tx_byte    = out_txb_q;
  assign rsp_o.read_valid = out_rdv_q;
  assign rsp_o.read_byte  = out_rdb_q;
  assign rsp_o.dropped    = out_drop_q;
  assign rsp_o.rx_level   = out_rxl_q;
  assign rsp_o.tx_level   = out_txl_q;

endmodule

FILE: sv/uart_console_echo_line_discipline_unit.sv
`timescale 1ns / 1ps

// Console UART line discipline with a receive FIFO and a transmit FIFO and
// optional terminal echo. Each request beat is one event (line byte,
// transmitter ready, host read, host write) and yields exactly one response
// beat. A front end classifies events into a two-entry command queue, so it
// keeps taking beats while the back end works, until the queue is full. The
// back end takes an event when idle, writes each byte it queues into the
// transmit FIFO in its push state, one byte per cycle. Reads, pops and plain
// stores queue nothing; an echoed printable byte or a host write queues its
// byte, CR or LF with echo LF and CR, and a DEL the erase sequence. The FIFO
// stores need no clearing after reset; only written entries are ever read.
module uart_console_echo_line_discipline_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  ucel_req_if.sink    req_i,
  ucel_rsp_if.source  rsp_o
);

  logic           fe_valid, fe_ready;
  ucel_pkg::cmd_t fe_cmd;
  logic           be_valid, be_ready;
  ucel_pkg::cmd_t be_cmd;

  ucel_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  ucel_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_cmd_i   (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_cmd_o    (be_cmd)
  );

  ucel_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (be_valid),
    .cmd_ready_o (be_ready),
    .cmd_i       (be_cmd),
    .rsp_o       (rsp_o)
  );

endmodule
